// File: rtl/ckb32_pkg.sv
// shared types, status codes and alphabet lookup for the base32 key decoder
package ckb32_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_CHAR  = 2'd1,
    STATUS_WRONG_LEN = 2'd2
  } status_t;

  localparam int unsigned SymbolBits = 5;
  localparam int unsigned AccBits    = 12;
  localparam int unsigned CountBits  = 4;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned EmitBits   = 6;

  typedef struct packed {
    logic                  skip;
    logic                  bad;
    logic [SymbolBits-1:0] value;
  } sym_t;

  typedef struct packed {
    logic                byte_valid;
    logic [ByteBits-1:0] out_byte;
    logic                done_res;
    status_t             status;
  } res_t;

  function automatic sym_t map_char(input logic [7:0] c);
    logic [7:0] u;
    sym_t       s;
    u       = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    s.skip  = 1'b0;
    s.bad   = 1'b0;
    s.value = '0;
    case (u)
      "-", " ", 8'h09, 8'h0A, 8'h0D, "_": s.skip = 1'b1;
      "0", "O": s.value = 5'd0;
      "1", "I", "L": s.value = 5'd1;
      "2": s.value = 5'd2;
      "3": s.value = 5'd3;
      "4": s.value = 5'd4;
      "5": s.value = 5'd5;
      "6": s.value = 5'd6;
      "7": s.value = 5'd7;
      "8": s.value = 5'd8;
      "9": s.value = 5'd9;
      "A": s.value = 5'd10;
      "B": s.value = 5'd11;
      "C": s.value = 5'd12;
      "D": s.value = 5'd13;
      "E": s.value = 5'd14;
      "F": s.value = 5'd15;
      "G": s.value = 5'd16;
      "H": s.value = 5'd17;
      "J": s.value = 5'd18;
      "K": s.value = 5'd19;
      "M": s.value = 5'd20;
      "N": s.value = 5'd21;
      "P": s.value = 5'd22;
      "Q": s.value = 5'd23;
      "R": s.value = 5'd24;
      "S": s.value = 5'd25;
      "T": s.value = 5'd26;
      "V": s.value = 5'd27;
      "W": s.value = 5'd28;
      "X": s.value = 5'd29;
      "Y": s.value = 5'd30;
      "Z": s.value = 5'd31;
      default: s.bad = 1'b1;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/ckb32_symbol_map.sv
// character classification and symbol value lookup
module ckb32_symbol_map (
  input  logic [7:0]     in_char,
  output ckb32_pkg::sym_t sym
);

  assign sym = ckb32_pkg::map_char(in_char);

endmodule

// File: rtl/ckb32_core.sv
// bit accumulator, byte counter, error swallow state and result register
module ckb32_core #(
  parameter int unsigned KEY_BYTES = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            item_valid,
  input  logic            item_last,
  input  ckb32_pkg::sym_t sym,
  output logic            res_valid,
  output ckb32_pkg::res_t res
);

  localparam logic [ckb32_pkg::EmitBits-1:0] KeyBytesW = ckb32_pkg::EmitBits'(KEY_BYTES);

  logic [ckb32_pkg::AccBits-1:0]   acc, acc_next, acc_shift;
  logic [ckb32_pkg::CountBits-1:0] count, count_next, count_sum;
  logic [ckb32_pkg::EmitBits-1:0]  emitted, emitted_next;
  logic                            swallow, swallow_next;
  logic                            emit;
  ckb32_pkg::res_t                 res_next;

  assign acc_shift = {acc[ckb32_pkg::AccBits-ckb32_pkg::SymbolBits-1:0], sym.value};
  assign count_sum = count + ckb32_pkg::CountBits'(ckb32_pkg::SymbolBits);

  always_comb begin
    acc_next          = acc;
    count_next        = count;
    emitted_next      = emitted;
    swallow_next      = swallow;
    emit              = 1'b0;
    res_next.byte_valid = 1'b0;
    res_next.out_byte = '0;
    res_next.done_res = 1'b0;
    res_next.status   = ckb32_pkg::STATUS_OK;
    if (item_valid) begin
      if (swallow) begin
        if (item_last) begin
          swallow_next = 1'b0;
        end
      end else if (!sym.skip && sym.bad) begin
        acc_next          = '0;
        count_next        = '0;
        emitted_next      = '0;
        swallow_next      = !item_last;
        emit              = 1'b1;
        res_next.done_res = 1'b1;
        res_next.status   = ckb32_pkg::STATUS_BAD_CHAR;
      end else begin
        if (!sym.skip) begin
          acc_next = acc_shift;
          if (count_sum >= ckb32_pkg::CountBits'(ckb32_pkg::ByteBits)) begin
            count_next          = count_sum - ckb32_pkg::CountBits'(ckb32_pkg::ByteBits);
            res_next.byte_valid = 1'b1;
            res_next.out_byte   = ckb32_pkg::ByteBits'(acc_shift >> count_next);
            if (emitted <= KeyBytesW) begin
              emitted_next = emitted + ckb32_pkg::EmitBits'(1);
            end
          end else begin
            count_next = count_sum;
          end
        end
        emit = res_next.byte_valid || item_last;
        if (item_last) begin
          res_next.done_res = 1'b1;
          res_next.status   = (emitted_next == KeyBytesW) ? ckb32_pkg::STATUS_OK
                                                          : ckb32_pkg::STATUS_WRONG_LEN;
          acc_next          = '0;
          count_next        = '0;
          emitted_next      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      count     <= '0;
      emitted   <= '0;
      swallow   <= 1'b0;
      res_valid <= 1'b0;
    end else if (advance) begin
      acc       <= acc_next;
      count     <= count_next;
      emitted   <= emitted_next;
      swallow   <= swallow_next;
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule

// File: rtl/crockford_base32_key_decoder.sv
// crockford base32 key decoder top level: input register, decode core, result port
//
// usage
//   request channel: char_valid/char_stall carry in_char and is_last, one key
//   character per request; is_last marks the final character of a key
//   result channel: result_valid/result_stall carry out_byte, byte_valid,
//   done_res and status; a result appears when a byte completes, when a key
//   ends, or both in one result, and also when a bad character is met
//   path: a request goes through the input register and then the result register
//   throughput: one request per cycle while the result side does not stall;
//   the combinational decode between input and result register sets this
//   reset: synchronous, clears the accumulator, counters and error state and
//   empties both registers, so the next character starts a new key
//   stall: a stalled result holds, and char_stall rises in the same cycle so
//   the whole pipeline freezes; nothing is dropped or repeated
//   characters after a bad one are swallowed until is_last, which gives no
//   further result
module crockford_base32_key_decoder #(
  parameter int unsigned KEY_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] in_char,
  input  logic       is_last,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       done_res,
  output logic [1:0] status
);

  logic            advance;
  logic            item_valid;
  logic [7:0]      item_char;
  logic            item_last;
  ckb32_pkg::sym_t sym;
  ckb32_pkg::res_t res;

  assign advance    = !(result_valid && result_stall);
  assign char_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (advance) begin
      item_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && char_valid) begin
      item_char <= in_char;
      item_last <= is_last;
    end
  end

  ckb32_symbol_map u_map (
    .in_char (item_char),
    .sym     (sym)
  );

  ckb32_core #(
    .KEY_BYTES (KEY_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item_valid (item_valid),
    .item_last  (item_last),
    .sym        (sym),
    .res_valid  (result_valid),
    .res        (res)
  );

  assign out_byte   = res.out_byte;
  assign byte_valid = res.byte_valid;
  assign done_res   = res.done_res;
  assign status     = res.status;

endmodule
